// ===== hdl/mciir_pkg.sv =====
// Package for the multichannel IIR filter: widths, register indexes, reset values,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mciir_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;

    // Configuration port
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;
    localparam int NUM_REGS = 8;

    // Register indexes
    localparam logic [2:0] REG_FF0   = 3'd0;
    localparam logic [2:0] REG_FF1   = 3'd1;
    localparam logic [2:0] REG_FF2   = 3'd2;
    localparam logic [2:0] REG_FF3   = 3'd3;
    localparam logic [2:0] REG_FB1   = 3'd4;
    localparam logic [2:0] REG_FB2   = 3'd5;
    localparam logic [2:0] REG_FB3   = 3'd6;
    localparam logic [2:0] REG_RECIP = 3'd7;

    // Taps per side that have a register (feedforward 0..3, feedback 1..3)
    localparam int COEF_TAPS = 4;

    // Reset values, 1.0 in Q2.14
    localparam logic [COEF_W-1:0] RST_UNITY = 16'h4000;

    // Rounding and saturation
    localparam int RND_SHIFT = 28;
    localparam int SAT_MAX   = 32767;
    localparam int SAT_MIN   = -32768;

    // Parameter defaults
    localparam int CHANNELS_DEF = 8;
    localparam int FF_TAPS_DEF  = 4;
    localparam int FB_TAPS_DEF  = 4;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ACC,
        S_SCALE,
        S_ROUND
    } t_state;

    typedef struct packed {
        logic load;     // capture item, read channel history
        logic mac;      // multiply current term
        logic scale;    // multiply sum by reciprocal
        logic out_load; // round, load output, write history back
    } t_dp_cmd;

    typedef struct packed {
        logic last_term;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/multichannel_iir_filter_top.sv =====
// Top level of the multichannel direct form I IIR filter: configuration registers,
// controller and datapath. Depends on mciir_pkg, mciir_cfg_regs, mciir_ctrl, mciir_dp.
//
//   Port group  Direction  Content
//   s_axis      in         tdata: sample; tuser: chan
//   m_axis      out        tdata: filtered; tuser: out_chan, clipped
//   apb         in/out     coefficient registers at byte address 4*index
//
// Each item goes through an accept step with the history read, one multiply per term
// on the shared multiplier, then accumulate, scale and round. The next item is
// accepted once the current one is written back. A result waiting in the output
// register stalls the block only at the round step. Reset clears the per-channel
// valid flags at once; no clearing pass is needed.
`default_nettype none

module multichannel_iir_filter_top
    import mciir_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int FF_TAPS  = FF_TAPS_DEF,
    parameter int FB_TAPS  = FB_TAPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,  // [15:0] sample
    input  wire logic [2:0]        s_axis_tuser,  // [2:0] chan
    // Output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [15:0]       m_axis_tdata,  // [15:0] filtered
    output logic      [3:0]        m_axis_tuser,  // [2:0] out_chan, [3] clipped
    // Configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    t_coef                      coef [NUM_REGS];
    t_dp_cmd                    dp_cmd;
    t_dp_sts                    dp_sts;
    logic        [CHAN_W-1:0]   out_chan;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;

    assign pready = 1'b1;

    mciir_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_coef    (coef)
    );

    mciir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    mciir_dp #(
        .CHANNELS (CHANNELS),
        .FF_TAPS  (FF_TAPS),
        .FB_TAPS  (FB_TAPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_chan     (s_axis_tuser),
        .i_sample   (s_axis_tdata),
        .i_coef     (coef),
        .o_out_chan (out_chan),
        .o_filtered (filtered),
        .o_clipped  (clipped)
    );

    assign m_axis_tdata = filtered;
    assign m_axis_tuser = {clipped, out_chan};

`ifndef ASSERT_OFF
    // The output register is loaded only when it is empty or being emptied
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while a result is held");

    // After an item is taken the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while an item is in progress");

    // Datapath commands never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load, dp_cmd.mac, dp_cmd.scale, dp_cmd.out_load}))
        else $error("overlapping datapath commands");

    // A result is loaded only after a scaling step
    a_scale_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.scale |=> (dp_cmd.out_load || !s_axis_tready))
        else $error("scaling not followed by the round step");
`endif

endmodule

`default_nettype wire

// ===== hdl/mciir_cfg_regs.sv =====
// Coefficient register bank behind the APB-style configuration port.
// Depends on mciir_pkg.
`default_nettype none

module mciir_cfg_regs
    import mciir_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [CFG_AW-1:0] i_paddr,
    input  wire logic [CFG_DW-1:0] i_pwdata,
    output logic      [CFG_DW-1:0] o_prdata,
    output t_coef                  o_coef [NUM_REGS]
);

    t_coef      r_coef [NUM_REGS];
    logic       w_wr;
    logic [2:0] w_idx;

    assign w_idx = i_paddr[CFG_AW-1:2];
    assign w_wr  = i_psel & i_penable & i_pwrite;

    // Register writes; tap 0 and the reciprocal reset to unity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i == int'(REG_FF0) || i == int'(REG_RECIP)) begin
                    r_coef[i] <= RST_UNITY;
                end else begin
                    r_coef[i] <= '0;
                end
            end
        end else if (w_wr) begin
            r_coef[w_idx] <= i_pwdata[COEF_W-1:0];
        end
    end

    // Read back, sign extended
    assign o_prdata = {{(CFG_DW-COEF_W){r_coef[w_idx][COEF_W-1]}}, r_coef[w_idx]};

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            o_coef[i] = r_coef[i];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mciir_ctrl.sv =====
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on mciir_pkg.
`default_nettype none

module mciir_ctrl
    import mciir_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (i_sts.last_term) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                // wait here while the previous result is still held
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid flag
    assign n_out_vld   = o_cmd.out_load | (r_out_vld & ~i_out_ready);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

// ===== hdl/mciir_dp.sv =====
// Datapath: per-channel history memory, shared multiply-accumulate unit, scaling
// multiplier, rounding/saturation and the output register. Depends on mciir_pkg.
`default_nettype none

module mciir_dp
    import mciir_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int FF_TAPS  = FF_TAPS_DEF,
    parameter int FB_TAPS  = FB_TAPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_sts                         o_sts,
    input  wire logic        [CHAN_W-1:0]   i_chan,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_coef                      i_coef [NUM_REGS],
    output logic             [CHAN_W-1:0]   o_out_chan,
    output logic signed      [SAMPLE_W-1:0] o_filtered,
    output logic                            o_clipped
);

    // Terms: x[n], FF_TAPS-1 past inputs, FB_TAPS-1 past outputs
    localparam int NT       = FF_TAPS + FB_TAPS - 1;
    localparam int HIST_N   = NT - 1;
    localparam int ROW_N    = (HIST_N > 0) ? HIST_N : 1;
    localparam int RI_W     = (ROW_N > 1) ? $clog2(ROW_N) : 1;
    localparam int TC_W     = $clog2(NT + 1);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACC_W    = PROD_W + 1 + $clog2(NT + 1);
    localparam int SCALED_W = ACC_W + COEF_W;
    localparam int Q_W      = SCALED_W + 1 - RND_SHIFT;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAT_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAT_MIN);

    // History memory: one row per channel, past inputs then past outputs
    logic [ROW_N-1:0][SAMPLE_W-1:0] r_mem [CHANNELS];
    logic [ROW_N-1:0][SAMPLE_W-1:0] r_row;
    logic [ROW_N-1:0][SAMPLE_W-1:0] w_new_row;
    logic [CHANNELS-1:0]            r_vld;

    logic        [CHAN_W-1:0]   r_chan;
    logic        [CH_W-1:0]     r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic        [TC_W-1:0]     r_term;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic                       r_prod_neg;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SCALED_W-1:0] r_scaled;

    logic        [6:0]          w_cm;
    logic        [CH_W-1:0]     w_ch;
    logic signed [SAMPLE_W-1:0] w_opnd;
    t_coef                      w_coef;
    logic        [TC_W-1:0]     w_fbj;
    logic signed [SCALED_W:0]   w_rnd;
    logic signed [Q_W-1:0]      w_q;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_clip;

    // Channel number modulo CHANNELS by repeated subtraction (at most seven steps)
    always_comb begin
        w_cm = 7'(i_chan);
        for (int i = 0; i < 8; i++) begin
            if (w_cm >= 7'(CHANNELS)) begin
                w_cm = w_cm - 7'(CHANNELS);
            end
        end
        w_ch = w_cm[CH_W-1:0];
    end

    // History memory: registered read on accept, write back with the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= r_vld[w_ch] ? r_mem[w_ch] : '0;
        end
        if (i_cmd.out_load) begin
            r_mem[r_ch] <= w_new_row;
        end
    end

    // Row valid flags stand in for clearing the history at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.out_load) begin
            r_vld[r_ch] <= 1'b1;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chan   <= i_chan;
            r_ch     <= w_ch;
            r_sample <= i_sample;
        end
    end

    // Operand: current sample for term 0, else history word term-1
    always_comb begin
        if (r_term == '0) begin
            w_opnd = r_sample;
        end else begin
            w_opnd = $signed(r_row[RI_W'(r_term - 1'b1)]);
        end
    end

    // Coefficient for the current term; taps without a register are zero
    always_comb begin
        w_coef = '0;
        w_fbj  = r_term - TC_W'(FF_TAPS - 1);
        if (r_term < FF_TAPS) begin
            if (r_term < COEF_TAPS) begin
                w_coef = i_coef[3'(r_term)];
            end
        end else if (w_fbj < COEF_TAPS) begin
            w_coef = i_coef[REG_FB1 + 3'(w_fbj) - 3'd1];
        end
    end

    assign o_sts.last_term = (r_term == TC_W'(NT - 1));

    // Multiply-accumulate: product registered, summed in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term     <= '0;
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mac;
            if (i_cmd.load) begin
                r_term <= '0;
            end else if (i_cmd.mac) begin
                r_term <= r_term + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac) begin
            r_prod     <= w_opnd * w_coef;
            r_prod_neg <= (r_term >= FF_TAPS);
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_neg) begin
                r_acc <= r_acc - ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (i_cmd.scale) begin
            r_scaled <= r_acc * i_coef[REG_RECIP];
        end
    end

    // Round to nearest (ties up) and saturate to Q1.15
    always_comb begin
        w_rnd  = (SCALED_W + 1)'(r_scaled) + ((SCALED_W + 1)'(1) << (RND_SHIFT - 1));
        w_q    = w_rnd[SCALED_W:RND_SHIFT];
        w_clip = 1'b0;
        w_y    = w_q[SAMPLE_W-1:0];
        if (w_q > Q_MAX) begin
            w_y    = Q_MAX[SAMPLE_W-1:0];
            w_clip = 1'b1;
        end else if (w_q < Q_MIN) begin
            w_y    = Q_MIN[SAMPLE_W-1:0];
            w_clip = 1'b1;
        end
    end

    // Shifted history row: new sample first, new output after the inputs
    always_comb begin
        for (int i = 0; i < ROW_N; i++) begin
            if (i == 0) begin
                w_new_row[i] = (FF_TAPS > 1) ? r_sample : w_y;
            end else if (i == FF_TAPS - 1) begin
                w_new_row[i] = w_y;
            end else begin
                w_new_row[i] = r_row[i-1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_chan <= r_chan;
            o_filtered <= w_y;
            o_clipped  <= w_clip;
        end
    end

endmodule

`default_nettype wire
